// ===== rtl/snet_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and helpers shared by the sorted note event table
// no dependencies
package snet_pkg;

    localparam int CAPACITY   = 256;
    localparam int FRAME_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > 9) ? CNT_W : 9;
    localparam int ENTRY_W    = 2 * FRAME_BITS + 24;
    localparam logic [15:0] VEL_ONE = 16'd32768;
    localparam logic [0:0]  REG_HIGHEST_NOTE = 1'b0;
    localparam logic [7:0]  HIGHEST_NOTE_RST = 8'd127;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_UPDATE = 3'd1,
        OP_REMOVE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_READ   = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_RM_RD, S_RM_WR, S_INS_INIT, S_INS_RD, S_INS_WR, S_INS_LAST, S_RD_WAIT
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  entry_index;
        logic [31:0] onset_frame;
        logic [31:0] duration;
        logic [7:0]  note_number;
        logic [15:0] velocity_level;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  result_index;
        logic [8:0]  entry_count;
        logic [31:0] read_start;
        logic [31:0] read_length;
        logic [7:0]  read_note;
        logic [15:0] read_velocity;
    } t_out_item;

    typedef struct packed {
        logic [FRAME_BITS-1:0] start;
        logic [FRAME_BITS-1:0] length;
        logic [7:0]            note;
        logic [15:0]           vel;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // true when a sorts strictly after b
    function automatic logic ev_after(input t_entry a, input t_entry b);
        if (a.start != b.start) begin
            return a.start > b.start;
        end
        if (a.note != b.note) begin
            return a.note > b.note;
        end
        return a.length > b.length;
    endfunction

endpackage

// ===== rtl/snet_mem.sv =====
`timescale 1ns / 1ps
// entry storage: one write port, one read port with registered data
// depends on snet_pkg
module snet_mem import snet_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/snet_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer: validates requests, walks the table to shift entries, holds the result
// depends on snet_pkg
module snet_ctrl import snet_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_highest_note,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    output t_mem_req   o_mem_req,
    input  t_entry     i_rdata
);

    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    t_entry            r_ev, n_ev;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    t_out_item         r_res, n_res;
    logic              r_done, n_done;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_out, n_out;

    t_entry            in_ev;
    logic              ev_ok;
    logic              idx_bad;
    logic [CNT_W-1:0]  pos;

    always_comb begin
        in_ev.start  = FRAME_BITS'(i_in.onset_frame);
        in_ev.length = FRAME_BITS'(i_in.duration);
        in_ev.note   = i_in.note_number;
        in_ev.vel    = i_in.velocity_level;
    end

    assign ev_ok   = (in_ev.length != '0) && (in_ev.note <= i_highest_note)
                     && (in_ev.vel <= VEL_ONE);
    assign idx_bad = CMP_W'(i_in.entry_index) >= CMP_W'(r_count);
    assign pos     = r_ptr + CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_ev      = r_ev;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_res     = r_res;
        n_done    = r_done;
        n_ovalid  = r_ovalid;
        n_out     = r_out;
        o_mem_req = '0;
        o_in_ready = (r_state == S_IDLE) && !r_done;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    // park the finished result once the output slot frees up
                    if (!r_ovalid || i_out_ready) begin
                        n_out             = r_res;
                        n_out.entry_count = 9'(r_count);
                        n_ovalid          = 1'b1;
                        n_done            = 1'b0;
                    end
                end else if (i_in_valid) begin
                    n_op  = i_in.opcode;
                    n_ev  = in_ev;
                    n_res = '0;
                    n_ptr = CNT_W'(i_in.entry_index) + CNT_W'(1);
                    n_done = 1'b1;
                    case (i_in.opcode)
                        OP_INSERT: begin
                            if (!ev_ok) begin
                                n_res.status = ST_INVALID;
                            end else if (CMP_W'(r_count) >= CMP_W'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_INS_INIT;
                            end
                        end
                        OP_UPDATE: begin
                            if (idx_bad) begin
                                n_res.status = ST_RANGE;
                            end else if (!ev_ok) begin
                                n_res.status = ST_INVALID;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_RM_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (idx_bad) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_RM_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_READ: begin
                            if (idx_bad) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = IDX_W'(i_in.entry_index);
                                n_done  = 1'b0;
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RM_RD: begin
                if (r_ptr >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_op == OP_UPDATE) begin
                        n_state = S_INS_INIT;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = IDX_W'(r_ptr);
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                // close the gap: entry at ptr moves down one place
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = IDX_W'(r_ptr - CNT_W'(1));
                o_mem_req.wdata = i_rdata;
                n_ptr   = pos;
                n_state = S_RM_RD;
            end
            S_INS_INIT: begin
                if (r_count == '0) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = '0;
                    o_mem_req.wdata = r_ev;
                    n_count = CNT_W'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = r_count - CNT_W'(1);
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = IDX_W'(r_ptr);
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                // walk down from the top, shifting up entries that sort after the new one
                o_mem_req.we = 1'b1;
                o_mem_req.waddr = IDX_W'(pos);
                if (ev_after(i_rdata, r_ev)) begin
                    o_mem_req.wdata = i_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        n_ptr   = r_ptr - CNT_W'(1);
                        n_state = S_INS_RD;
                    end
                end else begin
                    o_mem_req.wdata    = r_ev;
                    n_res.result_index = 8'(pos);
                    n_count = r_count + CNT_W'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INS_LAST: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = '0;
                o_mem_req.wdata = r_ev;
                n_res.result_index = '0;
                n_count = r_count + CNT_W'(1);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_RD_WAIT: begin
                n_res.read_start    = 32'(i_rdata.start);
                n_res.read_length   = 32'(i_rdata.length);
                n_res.read_note     = i_rdata.note;
                n_res.read_velocity = i_rdata.vel;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_done   <= n_done;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_ev  <= n_ev;
        r_ptr <= n_ptr;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

// ===== rtl/sorted_note_event_table_unit.sv =====
`timescale 1ns / 1ps
// sorted note event table top level: config register, sequencer and entry memory
// depends on snet_pkg, snet_mem, snet_ctrl
//
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_ready      i_in  (t_in_item)
// output    out        o_out_valid / i_out_ready    o_out (t_out_item)
// config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// one request at a time; the memory has one read and one write port
// insert: shifts up each entry after the new position, then writes the new entry;
//   into an empty table it writes the new entry directly
// remove: shifts down each entry after the index; update is remove then insert
// read: one registered memory read; clear and rejected requests touch no memory
// a result waits in the output register; the next request is taken meanwhile
// synchronous reset empties the table and sets highest_note to 127
module sorted_note_event_table_unit import snet_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_highest_note;
    t_mem_req   mem_req;
    t_entry     rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest_note <= HIGHEST_NOTE_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_HIGHEST_NOTE) begin
            r_highest_note <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HIGHEST_NOTE) ? {24'd0, r_highest_note} : 32'd0;

    snet_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_highest_note (r_highest_note),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in           (i_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out),
        .o_mem_req      (mem_req),
        .i_rdata        (rdata)
    );

    snet_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

endmodule

// ===== rtl/snet_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the sorted note event table, bound to the top level
// depends on snet_pkg
module snet_checker import snet_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in progress");

    a_idx_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.result_index == 8'd0)
        else $error("nonzero index on a failed request");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> CMP_W'(o_out.entry_count) <= CMP_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> CMP_W'(o_out.entry_count) == CMP_W'(CAPACITY))
        else $error("table full reported below capacity");

endmodule

bind sorted_note_event_table_unit snet_checker u_snet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
